@@ hw/rtl/kwm_pkg.sv @@
// kwm_pkg: sizes, codes, state encoding and shared types of the k-way chunk merge
// no dependencies; compiled first

package kwm_pkg;

  localparam int MAX_CHUNKS    = 16;
  localparam int MAX_CHUNK_LEN = 256;
  localparam int VALUE_BITS    = 32;

  localparam int CHUNK_BITS  = $clog2(MAX_CHUNKS);
  localparam int POS_BITS    = $clog2(MAX_CHUNK_LEN);
  localparam int CNT_BITS    = $clog2(MAX_CHUNKS + 1);
  localparam int CUR_BITS    = $clog2(MAX_CHUNK_LEN + 1);
  localparam int STORE_DEPTH = MAX_CHUNKS * MAX_CHUNK_LEN;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

  // field widths of the words
  localparam int FUNC_W   = 2;
  localparam int CSEL_W   = 4;
  localparam int POSF_W   = 8;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // configuration register widths and bus
  localparam int NUMC_W    = 5;
  localparam int LEN_W     = 9;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_NUM_CHUNKS   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CHUNK_LENGTH = REG_IDX_W'(1);

  localparam logic [NUMC_W-1:0] NUMC_RESET = NUMC_W'(1);
  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(256);

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE   = 2'd0,
    FN_RESTART = 2'd1,
    FN_TAKE    = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_TAKEN = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [NUMC_W-1:0] num_chunks;
    logic [LEN_W-1:0]  chunk_length;
  } cfg_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic                  re;
    logic [ADDR_BITS-1:0]  raddr;
  } mem_req_t;

endpackage

@@ hw/rtl/kwm_if.sv @@
// kwm_if: valid/ready channels for input and result words
// depends on kwm_pkg

interface kwm_in_if import kwm_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [CSEL_W-1:0]        chunk_select;
  logic [POSF_W-1:0]        position;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, func, chunk_select, position, data_value, input ready);
  modport sink   (input valid, func, chunk_select, position, data_value, output ready);
endinterface

interface kwm_out_if import kwm_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] merged_value;
  logic [CSEL_W-1:0]        source_chunk;
  logic [STATUS_W-1:0]      status;
  logic                     last_element;

  modport source (output valid, merged_value, source_chunk, status, last_element,
                  input ready);
  modport sink   (input valid, merged_value, source_chunk, status, last_element,
                  output ready);
endinterface

@@ hw/rtl/kwm_cfg.sv @@
// kwm_cfg: apb register file for chunk count and chunk length
// depends on kwm_pkg

module kwm_cfg import kwm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_chunks   <= NUMC_RESET;
      cfg.chunk_length <= LEN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NUM_CHUNKS:   cfg.num_chunks   <= pwdata[NUMC_W-1:0];
        REG_CHUNK_LENGTH: cfg.chunk_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_NUM_CHUNKS:   prdata = APB_DW'(cfg.num_chunks);
      REG_CHUNK_LENGTH: prdata = APB_DW'(cfg.chunk_length);
      default:          prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/kwm_store.sv @@
// kwm_store: element memory, one write port and one registered read port
// depends on kwm_pkg

module kwm_store import kwm_pkg::*; (
  input  logic                  clk,
  input  mem_req_t              req,
  output logic [VALUE_BITS-1:0] rd_data
);

  logic [VALUE_BITS-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

@@ hw/rtl/kwm_ctrl.sv @@
// kwm_ctrl: sequencer, chunk cursors, shared head comparator and result register
// depends on kwm_pkg, kwm_if; drives kwm_store

module kwm_ctrl import kwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  kwm_in_if.sink                in_ch,
  kwm_out_if.source             out_ch,
  input  cfg_t                  cfg,
  output mem_req_t              mem_req,
  input  logic [VALUE_BITS-1:0] rd_data
);

  state_t state, state_next;

  logic [FUNC_W-1:0]     op;
  logic [CHUNK_BITS-1:0] scan_idx;
  logic [CNT_BITS-1:0]   n_eff;
  logic [CUR_BITS-1:0]   len_eff;
  logic [CUR_BITS-1:0]   cursor [MAX_CHUNKS];

  logic                  pend_valid;
  logic [CHUNK_BITS-1:0] pend_chunk;
  logic [CUR_BITS-1:0]   pend_cur;

  logic                  found;
  logic                  multi;
  logic [VALUE_BITS-1:0] best_val;
  logic [CHUNK_BITS-1:0] best_chunk;
  logic [CUR_BITS-1:0]   best_cur;

  logic                  out_valid;
  logic [DATA_W-1:0]     out_value;
  logic [CSEL_W-1:0]     out_chunk;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_last;

  logic                  accept;
  logic                  out_free;
  logic [CNT_BITS-1:0]   n_sat;
  logic [CUR_BITS-1:0]   len_sat;
  logic [CUR_BITS-1:0]   scan_cur;
  logic                  scan_active;
  logic                  scan_last;
  logic                  take_better;
  logic [CUR_BITS:0]     best_cur_inc;
  logic                  remaining;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  assign n_sat   = (32'(cfg.num_chunks) > 32'(MAX_CHUNKS)) ? CNT_BITS'(MAX_CHUNKS)
                                                           : CNT_BITS'(cfg.num_chunks);
  assign len_sat = (32'(cfg.chunk_length) > 32'(MAX_CHUNK_LEN)) ? CUR_BITS'(MAX_CHUNK_LEN)
                                                                : CUR_BITS'(cfg.chunk_length);

  assign scan_cur    = cursor[scan_idx];
  assign scan_active = scan_cur < len_eff;
  assign scan_last   = CNT_BITS'(scan_idx) == (n_eff - CNT_BITS'(1));

  // the shared comparator: signed head against best so far, strict so lower chunk keeps ties
  assign take_better = pend_valid &&
                       (!found || ($signed(rd_data) < $signed(best_val)));

  assign best_cur_inc = {1'b0, best_cur} + (CUR_BITS + 1)'(1);
  assign remaining    = multi || (best_cur_inc < {1'b0, len_eff});

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.func == FN_TAKE && n_sat != '0) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake and memory port
  always_comb begin
    in_ch.ready   = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = {in_ch.chunk_select, in_ch.position};
    mem_req.wdata = VALUE_BITS'(in_ch.data_value);
    mem_req.re    = 1'b0;
    mem_req.raddr = {scan_idx, scan_cur[POS_BITS-1:0]};
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        mem_req.we  = in_ch.valid && (in_ch.func == FN_WRITE);
      end
      ST_SCAN:   mem_req.re = scan_active;
      ST_DRAIN:  ;
      ST_FINISH: ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // cursors: cleared by restart, advanced when a take finds a head
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHUNKS; i++) begin
        cursor[i] <= '0;
      end
    end else if (state == ST_IDLE && accept && in_ch.func == FN_RESTART) begin
      for (int i = 0; i < MAX_CHUNKS; i++) begin
        cursor[i] <= '0;
      end
    end else if (state == ST_FINISH && out_free && op == FN_TAKE && found) begin
      cursor[best_chunk] <= best_cur_inc[CUR_BITS-1:0];
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      found      <= 1'b0;
      multi      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          pend_valid <= 1'b0;
          found      <= 1'b0;
          multi      <= 1'b0;
        end
        ST_SCAN, ST_DRAIN: begin
          pend_valid <= (state == ST_SCAN) && scan_active;
          if (take_better) begin
            found <= 1'b1;
          end
          if (pend_valid && found) begin
            multi <= 1'b1;
          end
        end
        ST_FINISH: ;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      op       <= in_ch.func;
      n_eff    <= n_sat;
      len_eff  <= len_sat;
      scan_idx <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + CHUNK_BITS'(1);
    end
    if (state == ST_SCAN) begin
      pend_chunk <= scan_idx;
      pend_cur   <= scan_cur;
    end
    if (take_better && (state == ST_SCAN || state == ST_DRAIN)) begin
      best_val   <= rd_data;
      best_chunk <= pend_chunk;
      best_cur   <= pend_cur;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      if (op == FN_TAKE && found) begin
        out_value  <= DATA_W'(best_val);
        out_chunk  <= CSEL_W'(best_chunk);
        out_status <= STAT_TAKEN;
        out_last   <= !remaining;
      end else begin
        out_value  <= '0;
        out_chunk  <= '0;
        out_status <= (op == FN_TAKE) ? STAT_EMPTY : STAT_DONE;
        out_last   <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.merged_value = out_value;
  assign out_ch.source_chunk = out_chunk;
  assign out_ch.status       = out_status;
  assign out_ch.last_element = out_last;

  a_take_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && accept && in_ch.func == FN_TAKE && n_sat != '0) |=> state == ST_SCAN)
    else $error("take with chunks did not start a scan");

  a_scan_has_chunks: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> n_eff != '0)
    else $error("scan running with no chunks");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && found) |-> best_cur < len_eff)
    else $error("winning head beyond chunk length");

  a_last_only_taken: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> out_status == STAT_TAKEN)
    else $error("last flag on a word that took nothing");

endmodule

@@ hw/rtl/k_way_sorted_chunk_merge_top.sv @@
// k_way_sorted_chunk_merge_top: k-way merge of sorted chunks, linear head scan
// depends on kwm_pkg, kwm_if, kwm_cfg, kwm_store, kwm_ctrl
// write, restart, chunkless take: idle goes straight to finish, which loads the result word
// take: scans the heads of n chunks, then drains and finishes; n = effective chunk count (up to 16)
// the take time is set by one comparator fed from the single store read port, one head a cycle
// reset: cursors to zero, chunk count 1, chunk length 256; store contents undefined, no sweep

module k_way_sorted_chunk_merge_top import kwm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  kwm_in_if.sink            in_ch,
  kwm_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // configuration registers; the user must write them only while idle, the block does not enforce it
  cfg_t                  cfg;
  // request from the sequencer to the element store
  mem_req_t              mem_req;
  // registered head read, valid in the cycle after the request
  logic [VALUE_BITS-1:0] rd_data;

  kwm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // element store: chunk in the upper address bits, position in the lower
  kwm_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // sequencer: accepts a word in idle, for a take scans heads pipelined with the store read,
  // then loads the result register and frees the input side
  kwm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg     (cfg),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule
